@@ sv/bbf_pkg.sv @@
// Shared types, constants and the bit-mask function of the blocked Bloom filter.
`default_nettype none

package bbf_pkg;

    localparam int WORDS          = 4096;
    localparam int NUM_BITS       = 4;
    localparam int ADDR_W         = $clog2(WORDS);
    localparam int CFG_W          = 12;
    localparam int HASH_W         = 64;
    localparam int BYTES_PER_HASH = HASH_W / 8;
    localparam int POS_W          = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // One classified request on its way from the front part to the back part.
    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] addr;
        logic [HASH_W-1:0] bits;
    } item_t;

    // One bit for each of the top NUM_BITS bytes, each byte taken modulo 64.
    function automatic logic [HASH_W-1:0] bit_mask_of(input logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] m;
        logic [POS_W-1:0]  pos;
        m   = '0;
        pos = '0;
        for (int b = BYTES_PER_HASH - NUM_BITS; b < BYTES_PER_HASH; b++) begin
            pos    = hash[8*b +: POS_W];
            m[pos] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ sv/bbf_front.sv @@
// Front part: takes requests, works out word address and bit mask, hands them on.
`default_nettype none

module bbf_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     command,
    input  wire logic [63:0]              hash,
    input  wire logic [bbf_pkg::CFG_W-1:0] slot_mask,
    output logic                          push_valid,
    input  wire logic                     push_ready,
    output bbf_pkg::item_t                push_item
);
    import bbf_pkg::*;

    logic              stage_valid_reg;
    logic              stage_valid_next;
    item_t             stage_item_reg;
    logic [CFG_W-1:0]  idx;
    logic              take;

    // The stage can take a request when empty or when its content leaves now.
    assign in_stall = stage_valid_reg && !push_ready;
    assign take     = in_valid && !in_stall;
    assign idx      = hash[CFG_W-1:0] & slot_mask;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.command <= command;
            stage_item_reg.addr    <= ADDR_W'(idx);
            stage_item_reg.bits    <= bit_mask_of(hash);
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

`default_nettype wire

@@ sv/bbf_queue.sv @@
// Two-entry queue that decouples the front part from the back part.
`default_nettype none

module bbf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire bbf_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output bbf_pkg::item_t      pop_item
);
    import bbf_pkg::*;

    item_t       slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/bbf_back.sv @@
// Back part: clears the filter store, then reads, updates and tests one word per request.
`default_nettype none

module bbf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire bbf_pkg::item_t pop_item,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic                found
);
    import bbf_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } state_t;

    logic [HASH_W-1:0] mem [WORDS];

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    item_t             item_reg;
    logic [HASH_W-1:0] rdata_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic              out_free;
    logic              take;
    logic              finish;
    logic              hit;

    assign pop_ready = (state_reg == S_IDLE);
    assign take      = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == S_READ) && out_free;
    assign hit       = ((rdata_reg & item_reg.bits) == item_reg.bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= (item_reg.command == CMD_LOOKUP) && hit;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg  <= pop_item;
            rdata_reg <= mem[pop_item.addr];
        end
    end

    // Single write port: the clearing sweep, or the write-back of an insert.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (finish && (item_reg.command == CMD_INSERT))
        begin
            mem[item_reg.addr] <= rdata_reg | item_reg.bits;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

@@ sv/blocked_bloom_filter.sv @@
// Top level of the register-blocked Bloom filter: configuration register and the three parts.
`default_nettype none

//  Channel         Handshake                 Payload
//  request in      in_valid / in_stall       command, hash
//  result out      out_valid / out_stall     found
//  configuration   cfg_valid / cfg_ready     slot_index_mask
//
// In the back part a request first has its word read from the single-port filter store
// in S_IDLE, then in S_READ has the updated word written back and the result registered;
// a new request is taken only once the back part is through with the last one.
// After reset the back part sweeps the whole store to zero, one word a cycle;
// requests queue up in the front stage and the queue meanwhile.
// A stalled result holds the back part; the front stage and the two-entry queue keep
// taking requests until they are full, and only then is in_stall raised.
module blocked_bloom_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [63:0] hash,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] slot_index_mask
);
    import bbf_pkg::*;

    logic [CFG_W-1:0] slot_mask_reg;
    logic             push_valid;
    logic             push_ready;
    item_t            push_item;
    logic             pop_valid;
    logic             pop_ready;
    item_t            pop_item;

    // Always takes a mask write; the user must write only while idle, the block does not check.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slot_mask_reg <= slot_index_mask;
        end
    end

    // The front part works out the word address and bit mask of each request.
    bbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .hash       (hash),
        .slot_mask  (slot_mask_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // The queue lets the front part keep going while the back part is busy.
    bbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back part owns the filter store and the result register.  Because each
    // write-back finishes before the next read is issued, an insert is always seen
    // by any later request to the same word.
    bbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench of the register-blocked Bloom filter, with its own predictor.
`default_nettype none

module tb;

    import bbf_pkg::*;

    // A run with no accepted request, result or register write for this many cycles
    // is taken as hung. The limit leaves room for the quiet clearing sweep after reset.
    localparam int QUIET_LIMIT   = 20000;
    localparam int SHOWN_ERRORS  = 10;
    localparam int POOL_DEPTH    = 64;
    localparam int RANDOM_ITEMS  = 620;
    localparam int SETTLE_CYCLES = 8;

    // Hash bits that change neither the word index under a full mask nor any bit
    // position: the top two bits of each position byte, and bits 31..12.
    localparam logic [HASH_W-1:0] NEUTRAL_BITS = 64'hC0C0_C0C0_FFFF_F000;

    typedef struct {
        logic              found;
        logic              command;
        logic [HASH_W-1:0] hash;
    } outcome_t;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              in_valid        = 1'b0;
    logic              in_stall;
    logic              command         = CMD_INSERT;
    logic [HASH_W-1:0] hash            = '0;
    logic              out_valid;
    logic              out_stall       = 1'b0;
    logic              found;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  slot_index_mask = '1;

    // Predictor state: a copy of the filter store and of the slot-index mask.
    logic [HASH_W-1:0] filter_image [WORDS];
    logic [CFG_W-1:0]  slot_mask_image = '1;

    outcome_t          pending_outcomes[$];
    logic [HASH_W-1:0] inserted_hashes[$];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int inserts_sent    = 0;
    int lookups_sent    = 0;
    int lookups_hit     = 0;
    int mask_writes     = 0;

    blocked_bloom_filter u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .hash            (hash),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .slot_index_mask (slot_index_mask)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The position bits of a hash: one bit for each of the top NUM_BITS bytes, where
    // each byte is reduced to its low six bits. Equal bytes land on the same bit.
    function automatic logic [HASH_W-1:0] probe_bits(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] bits;
        bits = '0;
        for (int b = BYTES_PER_HASH - NUM_BITS; b < BYTES_PER_HASH; b++)
            bits = bits | (64'd1 << h[8*b +: POS_W]);
        return bits;
    endfunction

    // Applies one request to the predictor's store and returns the expected found flag.
    // An insert always answers 0; a lookup answers 1 only when every position bit is
    // already set, which includes an insert to the same word just before it.
    function automatic logic apply_request(input logic cmd, input logic [HASH_W-1:0] h);
        int unsigned       slot;
        logic [HASH_W-1:0] bits;
        slot = (h[CFG_W-1:0] & slot_mask_image) % WORDS;
        bits = probe_bits(h);
        if (cmd == CMD_INSERT)
        begin
            filter_image[slot] = filter_image[slot] | bits;
            return 1'b0;
        end
        return (filter_image[slot] & bits) == bits;
    endfunction

    function automatic logic [HASH_W-1:0] random_hash();
        return {$urandom, $urandom};
    endfunction

    // Offers one request, idling beforehand at the current sender rate. The request is
    // taken at the first rising edge with in_stall low, and its outcome is predicted
    // at that same edge so that the queue follows the order of acceptance.
    task automatic send_request(input logic cmd, input logic [HASH_W-1:0] h);
        outcome_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= cmd;
        hash     <= h;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        expected.found   = apply_request(cmd, h);
        expected.command = cmd;
        expected.hash    = h;
        pending_outcomes = {pending_outcomes, expected};
        if (cmd == CMD_INSERT)
            inserts_sent++;
        else
        begin
            lookups_sent++;
            if (expected.found)
                lookups_hit++;
        end
    endtask

    // Stops offering requests and waits until every outstanding result has come back,
    // then lets the block settle so that it is idle for a register write.
    task automatic drain_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the slot-index mask while the block is idle. The predictor takes the new
    // value at the edge where the write is accepted.
    task automatic write_slot_mask(input logic [CFG_W-1:0] value);
        drain_requests();
        @(negedge clk);
        cfg_valid       <= 1'b1;
        slot_index_mask <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        slot_mask_image = value;
        mask_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lookups into the empty store, then inserts followed at once by lookups of the
    // same word, so that a lookup right after a read-modify-write of its word is exercised.
    task automatic test_empty_and_forwarding();
        send_request(CMD_LOOKUP, '0);
        send_request(CMD_LOOKUP, '1);
        send_request(CMD_INSERT, '1);
        send_request(CMD_LOOKUP, '1);
        send_request(CMD_INSERT, '0);
        send_request(CMD_LOOKUP, '0);
        send_request(CMD_INSERT, {8'h11, 8'h22, 8'h33, 8'h04, 32'h0000_0555});
        send_request(CMD_LOOKUP, {8'h11, 8'h22, 8'h33, 8'h04, 32'h0000_0555});
        send_request(CMD_INSERT, {8'h15, 8'h26, 8'h37, 8'h08, 32'h0000_0555});
        send_request(CMD_LOOKUP, {8'h15, 8'h26, 8'h37, 8'h08, 32'h0000_0555});
        send_request(CMD_LOOKUP, {8'h11, 8'h26, 8'h33, 8'h08, 32'h0000_0555});
    endtask

    // Bit positions: the upper two bits of each byte and the low bytes above the index
    // must not matter, one wrong position must miss, and colliding bytes give a mask
    // with a single bit.
    task automatic test_bit_positions();
        send_request(CMD_LOOKUP, {8'h00, 8'h00, 8'h00, 8'h01, 32'h0000_0000});
        send_request(CMD_INSERT, {8'h20, 8'h3F, 8'h02, 8'h01, 32'h0000_0123});
        send_request(CMD_LOOKUP, {8'hE0, 8'hFF, 8'h82, 8'hC1, 32'hABCD_E123});
        send_request(CMD_LOOKUP, {8'h20, 8'h3F, 8'h02, 8'h03, 32'h0000_0123});
        send_request(CMD_INSERT, {8'h05, 8'h05, 8'h05, 8'h05, 32'h0000_0007});
        send_request(CMD_LOOKUP, {8'h45, 8'h85, 8'hC5, 8'h05, 32'hFFFF_F007});
        send_request(CMD_LOOKUP, {8'h05, 8'h05, 8'h05, 8'h05, 32'h0000_0008});
        send_request(CMD_LOOKUP, {8'h05, 8'h05, 8'h05, 8'h06, 32'h0000_0007});
    endtask

    // Both extremes of the mask, an irregular one and a one-bit one. With a zero mask every hash
    // falls on word 0, so a lookup differing only in its low 32 bits still hits.
    task automatic test_slot_mask_extremes();
        logic [HASH_W-1:0] h;
        h = random_hash();
        write_slot_mask('0);
        send_request(CMD_INSERT, h);
        send_request(CMD_LOOKUP, h ^ {32'h0, $urandom});
        send_request(CMD_LOOKUP, random_hash());
        write_slot_mask('1);
        send_request(CMD_LOOKUP, h);
        send_request(CMD_INSERT, h);
        send_request(CMD_LOOKUP, h ^ NEUTRAL_BITS);
        write_slot_mask(12'hA5A);
        send_request(CMD_INSERT, h);
        send_request(CMD_LOOKUP, h ^ {52'h0, ~12'hA5A});
        send_request(CMD_LOOKUP, h ^ {52'h0, 12'h002});
        write_slot_mask(12'h001);
        send_request(CMD_INSERT, random_hash());
        send_request(CMD_LOOKUP, random_hash());
    endtask

    // Random traffic under one mask. Most lookups revisit an earlier insert, often with
    // neutral bits flipped, so that hits are common; the rest are fresh hashes.
    task automatic test_random_traffic(input logic [CFG_W-1:0] mask, input int count);
        logic [HASH_W-1:0] h;
        int                pick;
        write_slot_mask(mask);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 40 || inserted_hashes.size() == 0)
            begin
                h = random_hash();
                if (inserted_hashes.size() < POOL_DEPTH)
                    inserted_hashes = {inserted_hashes, h};
                else
                    inserted_hashes[$urandom_range(POOL_DEPTH - 1)] = h;
                send_request(CMD_INSERT, h);
            end
            else if (pick < 75)
            begin
                h = inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
                if ($urandom_range(1))
                    h = h ^ (random_hash() & NEUTRAL_BITS);
                send_request(CMD_LOOKUP, h);
            end
            else
                send_request(CMD_LOOKUP, random_hash());
        end
    endtask

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        outcome_t expected;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_outcomes.size() == 0)
            begin
                if (mismatch_count < SHOWN_ERRORS)
                    $display("result %0d arrived with no request outstanding (found %0b)",
                             results_checked, found);
                mismatch_count++;
            end
            else
            begin
                expected = pending_outcomes.pop_front();
                if (found !== expected.found)
                begin
                    if (mismatch_count < SHOWN_ERRORS)
                        $display("result %0d: command %0b hash %h found expected %0b got %0b",
                                 results_checked, expected.command, expected.hash,
                                 expected.found, found);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if nothing at all has been accepted for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no progress for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_outcomes.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        foreach (filter_image[i])
            filter_image[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset mask, with the sender idling rarely and the
        // receiver stalling often.
        send_idle_pct = 13;
        stall_pct     = 75;
        test_empty_and_forwarding();
        test_bit_positions();
        test_slot_mask_extremes();

        // Random part: a small mask so words fill up and hits are frequent, then the
        // full mask, then a random mask, each with its own idling pattern.
        test_random_traffic(12'h03F, RANDOM_ITEMS);
        send_idle_pct = 75;
        stall_pct     = 13;
        test_random_traffic('1, RANDOM_ITEMS);
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_traffic(CFG_W'($urandom), RANDOM_ITEMS);

        drain_requests();
        repeat (16) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0d predicted results never arrived", pending_outcomes.size());
            mismatch_count += pending_outcomes.size();
        end

        $display("Covered %0d inserts and %0d lookups (%0d hits) over %0d mask settings.",
                 inserts_sent, lookups_sent, lookups_hit, mask_writes);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
